// File: sv/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// shared constants, codes and types of the region page allocator
// ----------------------------------------------------------------------------
package rpa_pkg;

  // pool geometry
  localparam int NUM_PAGES   = 64;
  localparam int PAGE_BYTES  = 16 * 1024;
  localparam int ALIGN_BYTES = 64;
  localparam int NUM_REGIONS = 4;

  // derived widths
  localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W      = $clog2(NUM_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int FILL_W     = $clog2(PAGE_BYTES + 1);
  localparam int RGN_W      = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  // transaction field widths
  localparam int ACTION_W    = 2;
  localparam int REGION_W    = 2;
  localparam int SIZE_W      = 16;
  localparam int PAGE_FLD_W  = 6;
  localparam int ADDR_W      = 20;
  localparam int STATUS_W    = 2;
  localparam int ASZ_W       = SIZE_W + 1;
  localparam int SUM_W       = ASZ_W + 1;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = ACTION_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - STATUS_W;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_TAKE    = 2'd1,
    ACT_GIVE    = 2'd2,
    ACT_COLLECT = 2'd3
  } rpa_act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FILL_RD,
    S_TAKE,
    S_TAKE_RD,
    S_TAKE_WR,
    S_LINK_WR,
    S_WALK_ISSUE,
    S_WALK_RD,
    S_FINISH
  } rpa_state_t;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic bump;
    logic take_pop_rd;
    logic take_pop;
    logic take_fresh;
    logic take_wr;
    logic link_wr;
    logic push_give;
    logic walk_start;
    logic walk_issue;
    logic walk_push;
    logic set_err1;
    logic set_err2;
    logic out_load;
  } rpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    rpa_act_t action;
    logic     region_ok;
    logic     too_big;
    logic     active;
    logic     free_nonempty;
    logic     fresh_avail;
    logic     give_ok;
    logic     fits;
    logic     walk_done;
    logic     out_free;
  } rpa_sts_t;

endpackage

// File: sv/region_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_page_allocator
// per-region bump allocator over a pool of fixed-size pages
// ----------------------------------------------------------------------------
// Takes one transaction at a time and returns exactly one result per
// transaction. Give-back and no-op items go from load straight to finish;
// an allocation that fits the region's last page first reads its fill; an
// allocation or bare take that needs a new page takes one, with a read of
// the link memory when popped from the free stack and a link write when
// chaining onto an existing region; a collect walks the region page by
// page through the single read port of the link memory. The sequencer
// returns to idle before the next item is accepted. A finished result sits
// in the output register, so the next transaction is taken while it waits;
// the block only holds off if a second result completes before the first
// has been taken. No clearing pass is needed after reset: page memories are
// only ever read at entries already written.
module region_page_allocator (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rpa_pkg::IN_TDATA_W-1:0]   s_tdata,  // region[1:0], size[17:2], page[23:18]
  input  logic [rpa_pkg::IN_TUSER_W-1:0]   s_tuser,  // action[1:0]
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rpa_pkg::OUT_TDATA_W-1:0]  m_tdata   // address[19:0], status[21:20], zero[23:22]
);

  // command and status between sequencer and datapath
  rpa_pkg::rpa_cmd_t cmd;
  rpa_pkg::rpa_sts_t sts;

  // sequencer: decodes the action and steps through memory accesses
  rpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: link and fill memories, free stack, region table, result register
  rpa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: sv/rpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ctrl
// sequencer of the allocator: one transaction at a time
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  rpa_pkg::rpa_sts_t sts,
  output rpa_pkg::rpa_cmd_t cmd
);

  rpa_pkg::rpa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rpa_pkg::S_IDLE: begin
        if (s_tvalid) state_next = rpa_pkg::S_LOAD;
      end
      rpa_pkg::S_LOAD: begin
        case (sts.action)
          rpa_pkg::ACT_ALLOC: begin
            if (!sts.region_ok || sts.too_big) state_next = rpa_pkg::S_FINISH;
            else if (!sts.active) state_next = rpa_pkg::S_TAKE;
            else state_next = rpa_pkg::S_FILL_RD;
          end
          rpa_pkg::ACT_TAKE: state_next = rpa_pkg::S_TAKE;
          rpa_pkg::ACT_COLLECT: begin
            if (sts.region_ok && sts.active) state_next = rpa_pkg::S_WALK_ISSUE;
            else state_next = rpa_pkg::S_FINISH;
          end
          default: state_next = rpa_pkg::S_FINISH;
        endcase
      end
      rpa_pkg::S_FILL_RD: begin
        if (sts.fits) state_next = rpa_pkg::S_FINISH;
        else state_next = rpa_pkg::S_TAKE;
      end
      rpa_pkg::S_TAKE: begin
        if (sts.free_nonempty) state_next = rpa_pkg::S_TAKE_RD;
        else if (sts.fresh_avail) state_next = rpa_pkg::S_TAKE_WR;
        else state_next = rpa_pkg::S_FINISH;
      end
      rpa_pkg::S_TAKE_RD: state_next = rpa_pkg::S_TAKE_WR;
      rpa_pkg::S_TAKE_WR: begin
        if (sts.action == rpa_pkg::ACT_ALLOC && sts.active) state_next = rpa_pkg::S_LINK_WR;
        else state_next = rpa_pkg::S_FINISH;
      end
      rpa_pkg::S_LINK_WR: state_next = rpa_pkg::S_FINISH;
      rpa_pkg::S_WALK_ISSUE: state_next = rpa_pkg::S_WALK_RD;
      rpa_pkg::S_WALK_RD: begin
        if (sts.walk_done) state_next = rpa_pkg::S_FINISH;
        else state_next = rpa_pkg::S_WALK_ISSUE;
      end
      rpa_pkg::S_FINISH: begin
        if (sts.out_free) state_next = rpa_pkg::S_IDLE;
      end
      default: state_next = rpa_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      rpa_pkg::S_IDLE: begin
        s_tready   = 1'b1;
        cmd.cap_in = s_tvalid;
      end
      rpa_pkg::S_LOAD: begin
        case (sts.action)
          rpa_pkg::ACT_ALLOC: begin
            cmd.set_err2 = sts.region_ok && sts.too_big;
          end
          rpa_pkg::ACT_GIVE: begin
            cmd.push_give = sts.give_ok;
          end
          rpa_pkg::ACT_COLLECT: begin
            cmd.walk_start = sts.region_ok && sts.active;
          end
          default: ;
        endcase
      end
      rpa_pkg::S_FILL_RD: begin
        cmd.bump = sts.fits;
      end
      rpa_pkg::S_TAKE: begin
        cmd.take_pop_rd = sts.free_nonempty;
        cmd.take_fresh  = !sts.free_nonempty && sts.fresh_avail;
        cmd.set_err1    = !sts.free_nonempty && !sts.fresh_avail;
      end
      rpa_pkg::S_TAKE_RD:    cmd.take_pop   = 1'b1;
      rpa_pkg::S_TAKE_WR:    cmd.take_wr    = 1'b1;
      rpa_pkg::S_LINK_WR:    cmd.link_wr    = 1'b1;
      rpa_pkg::S_WALK_ISSUE: cmd.walk_issue = 1'b1;
      rpa_pkg::S_WALK_RD:    cmd.walk_push  = 1'b1;
      rpa_pkg::S_FINISH:     cmd.out_load   = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/rpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_dp
// allocator datapath: page memories, free stack, region table, result register
// ----------------------------------------------------------------------------
module rpa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rpa_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [rpa_pkg::IN_TUSER_W-1:0]     s_tuser,
  input  rpa_pkg::rpa_cmd_t                  cmd,
  output rpa_pkg::rpa_sts_t                  sts,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rpa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // captured transaction
  rpa_pkg::rpa_act_t                 action_r;
  logic [rpa_pkg::REGION_W-1:0]      region_r;
  logic [rpa_pkg::SIZE_W-1:0]        size_r;
  logic [rpa_pkg::PAGE_FLD_W-1:0]    page_r;

  // allocator state
  logic [rpa_pkg::PG_W-1:0]          free_top;
  logic                              free_nonempty;
  logic [rpa_pkg::CNT_W-1:0]         fresh_count;
  logic [rpa_pkg::PG_W-1:0]          region_head [rpa_pkg::NUM_REGIONS];
  logic [rpa_pkg::PG_W-1:0]          region_tail [rpa_pkg::NUM_REGIONS];
  logic [rpa_pkg::NUM_REGIONS-1:0]   region_active;

  // working registers
  logic [rpa_pkg::PG_W-1:0]          pg_r;
  logic [rpa_pkg::PG_W-1:0]          cur_r;
  logic [rpa_pkg::PG_W-1:0]          n_r;
  logic [rpa_pkg::ADDR_W-1:0]        res_addr;
  logic [rpa_pkg::STATUS_W-1:0]      res_status;

  // memory ports
  logic                              link_we;
  logic [rpa_pkg::PG_W-1:0]          link_waddr, link_wdata, link_raddr, link_rdata;
  logic                              fill_we;
  logic [rpa_pkg::PG_W-1:0]          fill_waddr, fill_raddr;
  logic [rpa_pkg::FILL_W-1:0]        fill_wdata, fill_rdata;

  logic [rpa_pkg::RGN_W-1:0]         rg;
  logic [rpa_pkg::PG_W-1:0]          cur_tail, cur_head;
  logic                              cur_active;
  logic [rpa_pkg::ASZ_W-1:0]         round_sum, asz_raw, asz;
  logic [rpa_pkg::SUM_W-1:0]         fill_sum;
  logic                              nxt_bad, pop_bottom, walk_done, alloc_new;
  logic [rpa_pkg::PG_W-1:0]          push_pg, push_link;

  rpa_ram #(.WIDTH(rpa_pkg::PG_W), .DEPTH(rpa_pkg::NUM_PAGES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  rpa_ram #(.WIDTH(rpa_pkg::FILL_W), .DEPTH(rpa_pkg::NUM_PAGES)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  assign rg         = rpa_pkg::RGN_W'(region_r);
  assign cur_tail   = region_tail[rg];
  assign cur_head   = region_head[rg];
  assign cur_active = region_active[rg];
  assign alloc_new  = (action_r == rpa_pkg::ACT_ALLOC) && !cur_active;

  // round up to the alignment, an empty request still takes one granule
  assign round_sum = rpa_pkg::ASZ_W'(size_r) + rpa_pkg::ASZ_W'(rpa_pkg::ALIGN_BYTES - 1);
  assign asz_raw   = round_sum & ~rpa_pkg::ASZ_W'(rpa_pkg::ALIGN_BYTES - 1);
  assign asz       = (asz_raw == '0) ? rpa_pkg::ASZ_W'(rpa_pkg::ALIGN_BYTES) : asz_raw;
  assign fill_sum  = rpa_pkg::SUM_W'(fill_rdata) + rpa_pkg::SUM_W'(asz);

  // free stack and chain walk
  assign nxt_bad    = (rpa_pkg::CNT_W + 1)'(link_rdata) >= (rpa_pkg::CNT_W + 1)'(rpa_pkg::NUM_PAGES);
  assign pop_bottom = (link_rdata == pg_r) || nxt_bad;
  assign walk_done  = (cur_r == cur_tail) || nxt_bad ||
                      (n_r == rpa_pkg::PG_W'(rpa_pkg::NUM_PAGES - 1));
  assign push_pg    = cmd.walk_push ? cur_r : rpa_pkg::PG_W'(page_r);
  assign push_link  = free_nonempty ? free_top : push_pg;

  always_comb begin
    sts.action        = action_r;
    sts.region_ok     = 32'(region_r) < 32'(rpa_pkg::NUM_REGIONS);
    sts.too_big       = asz > rpa_pkg::ASZ_W'(rpa_pkg::PAGE_BYTES);
    sts.active        = cur_active;
    sts.free_nonempty = free_nonempty;
    sts.fresh_avail   = fresh_count < rpa_pkg::CNT_W'(rpa_pkg::NUM_PAGES);
    sts.give_ok       = 32'(page_r) < 32'(fresh_count);
    sts.fits          = fill_sum <= rpa_pkg::SUM_W'(rpa_pkg::PAGE_BYTES);
    sts.walk_done     = walk_done;
    sts.out_free      = !m_tvalid || m_tready;
  end

  // link memory port muxing
  always_comb begin
    link_we    = 1'b0;
    link_waddr = pg_r;
    link_wdata = pg_r;
    if (cmd.take_wr) begin
      link_we = 1'b1;
    end else if (cmd.link_wr) begin
      link_we    = 1'b1;
      link_waddr = cur_tail;
    end else if (cmd.push_give || cmd.walk_push) begin
      link_we    = 1'b1;
      link_waddr = push_pg;
      link_wdata = push_link;
    end
  end

  assign link_raddr = cmd.walk_issue ? cur_r : free_top;

  // fill memory: fresh page or bump of the tail page
  assign fill_we    = cmd.take_wr || cmd.bump;
  assign fill_waddr = cmd.take_wr ? pg_r : cur_tail;
  assign fill_wdata = cmd.take_wr ?
                      ((action_r == rpa_pkg::ACT_ALLOC) ? rpa_pkg::FILL_W'(asz) : '0) :
                      rpa_pkg::FILL_W'(fill_sum);
  assign fill_raddr = cur_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top      <= '0;
      free_nonempty <= 1'b0;
      fresh_count   <= '0;
      region_active <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.push_give || cmd.walk_push) begin
        free_top      <= push_pg;
        free_nonempty <= 1'b1;
      end
      if (cmd.take_pop) begin
        if (pop_bottom) free_nonempty <= 1'b0;
        else free_top <= link_rdata;
      end
      if (cmd.take_fresh) begin
        fresh_count <= fresh_count + 1'b1;
      end
      if (cmd.take_wr && alloc_new) begin
        region_active[rg] <= 1'b1;
      end
      if (cmd.walk_push && walk_done) begin
        region_active[rg] <= 1'b0;
      end
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      action_r   <= rpa_pkg::rpa_act_t'(s_tuser);
      region_r   <= s_tdata[rpa_pkg::REGION_W-1:0];
      size_r     <= s_tdata[rpa_pkg::REGION_W +: rpa_pkg::SIZE_W];
      page_r     <= s_tdata[rpa_pkg::REGION_W + rpa_pkg::SIZE_W +: rpa_pkg::PAGE_FLD_W];
      res_addr   <= '0;
      res_status <= rpa_pkg::ST_OK;
    end
    if (cmd.take_pop_rd) pg_r <= free_top;
    if (cmd.take_fresh) pg_r <= rpa_pkg::PG_W'(fresh_count);
    if (cmd.take_wr) begin
      res_addr <= rpa_pkg::ADDR_W'({pg_r, {rpa_pkg::PAGE_SHIFT{1'b0}}});
      if (alloc_new) begin
        region_head[rg] <= pg_r;
        region_tail[rg] <= pg_r;
      end
    end
    if (cmd.link_wr) region_tail[rg] <= pg_r;
    if (cmd.bump) begin
      res_addr <= rpa_pkg::ADDR_W'({cur_tail, fill_rdata[rpa_pkg::PAGE_SHIFT-1:0]});
    end
    if (cmd.set_err1) res_status <= rpa_pkg::ST_NO_PAGE;
    if (cmd.set_err2) res_status <= rpa_pkg::ST_TOO_BIG;
    if (cmd.walk_start) begin
      cur_r <= cur_head;
      n_r   <= '0;
    end
    if (cmd.walk_push) begin
      cur_r <= link_rdata;
      n_r   <= n_r + 1'b1;
    end
    if (cmd.out_load) begin
      m_tdata <= {{rpa_pkg::OUT_PAD_W{1'b0}}, res_status, res_addr};
    end
  end

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take_fresh |-> fresh_count < rpa_pkg::CNT_W'(rpa_pkg::NUM_PAGES))
    else $error("fresh page taken with pool used up");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.take_pop_rd |-> free_nonempty)
    else $error("pop from empty free stack");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result not presented after load");

  a_too_big: assert property (@(posedge clk) disable iff (rst)
    cmd.set_err2 |=> (res_addr == '0) && (res_status == rpa_pkg::ST_TOO_BIG))
    else $error("oversized request left an address");

endmodule
